### rtl/lrr_pkg.sv
// Shared types, constants and arithmetic helpers of the leaky reservoir block.
package lrr_pkg;

  localparam int MaxNeurons = 64;
  localparam int MaxInputs  = 64;
  localparam int MaxOutputs = 16;
  localparam int MaxSteps   = 16;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_ELEM  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] TBL_WIN   = 3'd0;
  localparam logic [2:0] TBL_WREC  = 3'd1;
  localparam logic [2:0] TBL_WOUT  = 3'd2;
  localparam logic [2:0] TBL_BREC  = 3'd3;
  localparam logic [2:0] TBL_BOUT  = 3'd4;
  localparam logic [2:0] TBL_TAU   = 3'd5;
  localparam logic [2:0] TBL_STATE = 3'd6;

  localparam logic [2:0] REG_RESERVOIR = 3'd0;
  localparam logic [2:0] REG_INPUTS    = 3'd1;
  localparam logic [2:0] REG_OUTPUTS   = 3'd2;
  localparam logic [2:0] REG_STEPS     = 3'd3;
  localparam logic [2:0] REG_TIMESTEP  = 3'd4;

  localparam logic signed [15:0] OP_ONE = 16'sd4096;
  localparam logic [12:0] TANH_LAST = 13'd4093;

  localparam logic [12:0] TANH_TAB [17] = '{
    13'd0, 13'd1003, 13'd1893, 13'd2602, 13'd3119, 13'd3475, 13'd3707, 13'd3856,
    13'd3949, 13'd4006, 13'd4041, 13'd4062, 13'd4076, 13'd4084, 13'd4089,
    13'd4091, 13'd4093
  };

  typedef enum logic [2:0] {
    SRC_NONE, SRC_BIASN, SRC_IN, SRC_REC, SRC_BIASO, SRC_OUT, SRC_XR, SRC_COPY
  } src_e;

  typedef struct packed {
    logic [6:0]  reservoir_used;
    logic [6:0]  inputs_used;
    logic [4:0]  outputs_used;
    logic [4:0]  euler_steps;
    logic [14:0] time_step;
  } cfg_t;

  typedef struct packed {
    src_e       src;
    logic [5:0] row;
    logic [5:0] col;
    logic       acc_clr;
    logic       div_start;
    logic       net_ld;
    logic       tanh_ld;
    logic       upd_mul;
    logic       upd_wr;
    logic       out_ld;
    logic       out_last;
    logic       tbl_wr;
    logic       elem_wr;
    logic       clr;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
    logic out_free;
  } stat_t;

  function automatic logic signed [35:0] round_q12(input logic signed [47:0] a);
    logic signed [47:0] s;
    s = a + 48'sd2048;
    return s[47:12];
  endfunction

  function automatic logic signed [15:0] sat_data(input logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    if (v < -36'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] tanh_q(input logic signed [35:0] net);
    logic [35:0] a;
    logic [3:0]  k;
    logic [9:0]  f;
    logic [12:0] lo;
    logic [12:0] hi;
    logic [12:0] y;
    logic [22:0] p;
    a  = net[35] ? 36'(-net) : 36'(net);
    k  = a[13:10];
    f  = a[9:0];
    lo = TANH_TAB[k];
    hi = TANH_TAB[5'(k) + 5'd1];
    p  = 23'(hi - lo) * 23'(f) + 23'd512;
    y  = lo + p[22:10];
    if (|a[35:14]) y = TANH_LAST;
    return net[35] ? -16'(signed'({3'b000, y})) : 16'(signed'({3'b000, y}));
  endfunction

endpackage

### rtl/leaky_reservoir_rnn_forward.sv
// Top level of the leaky-integrator reservoir network, forward pass.
// Table writes, state clears and non-final input elements are handled without leaving idle.
// A final element runs S Euler steps of R neurons, each neuron on the single MAC and the
// alpha divider, each step ending in a state copy; each readout then runs on the same MAC.
// Input is taken again once the last result sits in the output register.
// Reset clears control and state-valid flags.
module leaky_reservoir_rnn_forward (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [2:0]         table_select_i,
  input  logic [5:0]         row_index_i,
  input  logic [5:0]         column_index_i,
  input  logic signed [15:0] value_i,
  input  logic               last_element_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_index_o,
  output logic signed [15:0] out_value_o,
  output logic               out_last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lrr_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  lrr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lrr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .last_element_i (last_element_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  lrr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_i          (cfg),
    .table_select_i (table_select_i),
    .row_index_i    (row_index_i),
    .column_index_i (column_index_i),
    .value_i        (value_i),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_index_o    (out_index_o),
    .out_value_o    (out_value_o),
    .out_last_o     (out_last_o)
  );

endmodule

### rtl/lrr_cfg.sv
// Configuration register bank behind the APB-style port.
module lrr_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output lrr_pkg::cfg_t cfg_o
);
  import lrr_pkg::*;

  cfg_t cfg_q;
  logic wr;
  logic [6:0] v7;
  logic [4:0] v5;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign v7     = pwdata[6:0];
  assign v5     = pwdata[4:0];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reservoir_used <= 7'd64;
      cfg_q.inputs_used    <= 7'd16;
      cfg_q.outputs_used   <= 5'd16;
      cfg_q.euler_steps    <= 5'd1;
      cfg_q.time_step      <= 15'd410;
    end else if (wr) begin
      case (paddr[4:2])
        REG_RESERVOIR: begin
          cfg_q.reservoir_used <= (v7 == 7'd0) ? 7'd1 :
                                  (v7 > 7'(MaxNeurons)) ? 7'(MaxNeurons) : v7;
        end
        REG_INPUTS: begin
          cfg_q.inputs_used <= (v7 == 7'd0) ? 7'd1 :
                               (v7 > 7'(MaxInputs)) ? 7'(MaxInputs) : v7;
        end
        REG_OUTPUTS: begin
          cfg_q.outputs_used <= (v5 == 5'd0) ? 5'd1 :
                                (v5 > 5'(MaxOutputs)) ? 5'(MaxOutputs) : v5;
        end
        REG_STEPS: begin
          cfg_q.euler_steps <= (v5 == 5'd0) ? 5'd1 :
                               (v5 > 5'(MaxSteps)) ? 5'(MaxSteps) : v5;
        end
        REG_TIMESTEP: begin
          cfg_q.time_step <= pwdata[14:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_RESERVOIR: prdata = {25'd0, cfg_q.reservoir_used};
      REG_INPUTS:    prdata = {25'd0, cfg_q.inputs_used};
      REG_OUTPUTS:   prdata = {27'd0, cfg_q.outputs_used};
      REG_STEPS:     prdata = {27'd0, cfg_q.euler_steps};
      REG_TIMESTEP:  prdata = {17'd0, cfg_q.time_step};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

### rtl/lrr_div.sv
// Bit-serial restoring divider that forms alpha = dt / tau in Q.12.
module lrr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [14:0]        dt_i,
  input  logic signed [15:0] tau_i,
  output logic               busy_o,
  output logic [15:0]        alpha_o
);
  logic [27:0] dq_q;
  logic [14:0] rem_q;
  logic [14:0] den_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [15:0] trial;
  logic        fit;

  assign trial   = {rem_q, dq_q[27]};
  assign fit     = trial >= {1'b0, den_q};
  assign busy_o  = busy_q;
  assign alpha_o = (|dq_q[27:16]) ? 16'hffff : dq_q[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else if (start_i) begin
      busy_q <= !(tau_i[15] || tau_i == 16'sd0);
      cnt_q  <= 5'd28;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 5'd1;
      busy_q <= cnt_q != 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 15'd0;
      den_q <= tau_i[14:0];
      if (tau_i[15] || tau_i == 16'sd0) begin
        dq_q <= '1;
      end else begin
        dq_q <= {1'b0, dt_i, 12'd0} + {14'd0, tau_i[14:1]};
      end
    end else if (busy_q) begin
      rem_q <= fit ? 15'(trial - {1'b0, den_q}) : trial[14:0];
      dq_q  <= {dq_q[26:0], fit};
    end
  end

endmodule

### rtl/lrr_dp.sv
// Datapath: table memories, neuron state, MAC pipeline, update and output register.
module lrr_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrr_pkg::cmd_t      cmd_i,
  input  lrr_pkg::cfg_t      cfg_i,
  input  logic [2:0]         table_select_i,
  input  logic [5:0]         row_index_i,
  input  logic [5:0]         column_index_i,
  input  logic signed [15:0] value_i,
  output lrr_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_index_o,
  output logic signed [15:0] out_value_o,
  output logic               out_last_o
);
  import lrr_pkg::*;

  logic signed [15:0] win_mem  [MaxNeurons * MaxInputs];
  logic signed [15:0] wrec_mem [MaxNeurons * MaxNeurons];
  logic signed [15:0] wout_mem [MaxOutputs * MaxNeurons];
  logic signed [15:0] b_mem    [MaxNeurons];
  logic signed [15:0] bo_mem   [MaxOutputs];
  logic signed [15:0] tau_mem  [MaxNeurons];
  logic signed [15:0] x_mem    [MaxNeurons];
  logic signed [15:0] nx_mem   [MaxNeurons];
  logic signed [15:0] u_mem    [MaxInputs];
  logic [MaxNeurons-1:0] xv_q;

  logic signed [15:0] win_q, wrec_q, wout_q, b_q, bo_q, tau_q, x_q, nx_q, u_q;
  logic xvr_q;
  src_e src1_q;
  logic mv1_q, mv2_q;
  logic signed [31:0] prod_q;
  logic signed [47:0] acc_q;
  logic signed [35:0] net_q;
  logic signed [15:0] t_q, xr_q;
  logic signed [33:0] prod2_q;
  logic cp_v_q;
  logic [5:0] cp_row_q;
  logic [5:0] x_raddr;
  logic signed [15:0] w, op, xop;
  logic signed [16:0] tx;
  logic signed [47:0] upd_sum;
  logic [15:0] alpha;
  logic div_busy;
  logic out_valid_q;
  logic [3:0] out_index_q;
  logic signed [15:0] out_value_q;
  logic out_last_q;
  logic tbl_row_ok;

  assign x_raddr    = (cmd_i.src == SRC_XR) ? cmd_i.row : cmd_i.col;
  assign tbl_row_ok = row_index_i[5:4] == 2'b00;

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && table_select_i == TBL_WIN)
      win_mem[{row_index_i, column_index_i}] <= value_i;
    win_q <= win_mem[{cmd_i.row, cmd_i.col}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && table_select_i == TBL_WREC)
      wrec_mem[{row_index_i, column_index_i}] <= value_i;
    wrec_q <= wrec_mem[{cmd_i.row, cmd_i.col}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && table_select_i == TBL_WOUT && tbl_row_ok)
      wout_mem[{row_index_i[3:0], column_index_i}] <= value_i;
    wout_q <= wout_mem[{cmd_i.row[3:0], cmd_i.col}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && table_select_i == TBL_BREC)
      b_mem[row_index_i] <= value_i;
    b_q <= b_mem[cmd_i.row];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && table_select_i == TBL_BOUT && tbl_row_ok)
      bo_mem[row_index_i[3:0]] <= value_i;
    bo_q <= bo_mem[cmd_i.row[3:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && table_select_i == TBL_TAU)
      tau_mem[row_index_i] <= value_i;
    tau_q <= tau_mem[cmd_i.row];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.elem_wr)
      u_mem[column_index_i] <= value_i;
    u_q <= u_mem[cmd_i.col];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_wr)
      nx_mem[cmd_i.row] <= sat_data(round_q12(upd_sum));
    nx_q <= nx_mem[cmd_i.row];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_wr && table_select_i == TBL_STATE)
      x_mem[row_index_i] <= value_i;
    else if (cp_v_q)
      x_mem[cp_row_q] <= nx_q;
    x_q   <= x_mem[x_raddr];
    xvr_q <= xv_q[x_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xv_q <= '0;
    end else if (cmd_i.clr) begin
      xv_q <= '0;
    end else if (cmd_i.tbl_wr && table_select_i == TBL_STATE) begin
      xv_q[row_index_i] <= 1'b1;
    end else if (cp_v_q) begin
      xv_q[cp_row_q] <= 1'b1;
    end
  end

  assign xop = xvr_q ? x_q : 16'sd0;

  always_comb begin
    case (src1_q)
      SRC_BIASN: begin w = b_q;    op = OP_ONE; end
      SRC_IN:    begin w = win_q;  op = u_q;    end
      SRC_REC:   begin w = wrec_q; op = xop;    end
      SRC_BIASO: begin w = bo_q;   op = OP_ONE; end
      SRC_OUT:   begin w = wout_q; op = xop;    end
      default:   begin w = 16'sd0; op = 16'sd0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src1_q <= SRC_NONE;
      mv1_q  <= 1'b0;
      mv2_q  <= 1'b0;
      cp_v_q <= 1'b0;
    end else begin
      src1_q <= cmd_i.src;
      mv1_q  <= cmd_i.src == SRC_BIASN || cmd_i.src == SRC_IN || cmd_i.src == SRC_REC ||
                cmd_i.src == SRC_BIASO || cmd_i.src == SRC_OUT;
      mv2_q  <= mv1_q;
      cp_v_q <= cmd_i.src == SRC_COPY;
    end
  end

  assign tx      = {t_q[15], t_q} - {xr_q[15], xr_q};
  assign upd_sum = {{20{xr_q[15]}}, xr_q, 12'd0} + 48'(prod2_q);

  always_ff @(posedge clk_i) begin
    prod_q   <= w * op;
    cp_row_q <= cmd_i.row;
    if (cmd_i.acc_clr)
      acc_q <= 48'sd0;
    else if (mv2_q)
      acc_q <= acc_q + 48'(prod_q);
    if (cmd_i.net_ld)
      net_q <= round_q12(acc_q);
    if (cmd_i.tanh_ld) begin
      t_q  <= tanh_q(net_q);
      xr_q <= xop;
    end
    if (cmd_i.upd_mul)
      prod2_q <= 34'($signed({1'b0, alpha})) * 34'(tx);
  end

  lrr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .dt_i    (cfg_i.time_step),
    .tau_i   (tau_q),
    .busy_o  (div_busy),
    .alpha_o (alpha)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_index_q <= cmd_i.row[3:0];
      out_value_q <= sat_data(round_q12(acc_q));
      out_last_q  <= cmd_i.out_last;
    end
  end

  assign stat_o.pipe_busy = mv1_q | mv2_q;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = !out_valid_q | out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_index_o      = out_index_q;
  assign out_value_o      = out_value_q;
  assign out_last_o       = out_last_q;

endmodule

### rtl/lrr_ctrl.sv
// Controller: input decode and sequencing of the Euler steps and the readout.
module lrr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lrr_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     action_i,
  input  logic           last_element_i,
  input  lrr_pkg::stat_t stat_i,
  output lrr_pkg::cmd_t  cmd_o
);
  import lrr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NBIAS, ST_NIN, ST_NREC, ST_NDRAIN, ST_NNET, ST_NTANH, ST_NDIV,
    ST_NUPD, ST_COPY, ST_COPYW, ST_OBIAS, ST_OMAC, ST_ODRAIN, ST_OWAIT
  } state_e;

  state_e state_q;
  logic [6:0] r_q;
  logic [6:0] c_q;
  logic [4:0] s_q;
  logic accept;
  logic r_last, i_last, rc_last, o_last, s_last;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && state_q == ST_IDLE;
  assign r_last     = r_q == cfg_i.reservoir_used - 7'd1;
  assign rc_last    = c_q == cfg_i.reservoir_used - 7'd1;
  assign i_last     = c_q == cfg_i.inputs_used - 7'd1;
  assign o_last     = r_q == {2'b00, cfg_i.outputs_used} - 7'd1;
  assign s_last     = s_q == cfg_i.euler_steps - 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      r_q     <= 7'd0;
      c_q     <= 7'd0;
      s_q     <= 5'd0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && action_i == ACT_ELEM && last_element_i) begin
            r_q     <= 7'd0;
            s_q     <= 5'd0;
            state_q <= ST_NBIAS;
          end
        end
        ST_NBIAS: begin
          c_q     <= 7'd0;
          state_q <= ST_NIN;
        end
        ST_NIN: begin
          c_q <= i_last ? 7'd0 : c_q + 7'd1;
          if (i_last) state_q <= ST_NREC;
        end
        ST_NREC: begin
          c_q <= c_q + 7'd1;
          if (rc_last) state_q <= ST_NDRAIN;
        end
        ST_NDRAIN: begin
          if (!stat_i.pipe_busy) state_q <= ST_NNET;
        end
        ST_NNET: begin
          state_q <= ST_NTANH;
        end
        ST_NTANH: begin
          state_q <= ST_NDIV;
        end
        ST_NDIV: begin
          if (!stat_i.div_busy) state_q <= ST_NUPD;
        end
        ST_NUPD: begin
          r_q     <= r_last ? 7'd0 : r_q + 7'd1;
          state_q <= r_last ? ST_COPY : ST_NBIAS;
        end
        ST_COPY: begin
          r_q <= r_q + 7'd1;
          if (r_last) state_q <= ST_COPYW;
        end
        ST_COPYW: begin
          r_q     <= 7'd0;
          s_q     <= s_last ? 5'd0 : s_q + 5'd1;
          state_q <= s_last ? ST_OBIAS : ST_NBIAS;
        end
        ST_OBIAS: begin
          c_q     <= 7'd0;
          state_q <= ST_OMAC;
        end
        ST_OMAC: begin
          c_q <= c_q + 7'd1;
          if (rc_last) state_q <= ST_ODRAIN;
        end
        ST_ODRAIN: begin
          if (!stat_i.pipe_busy) state_q <= ST_OWAIT;
        end
        ST_OWAIT: begin
          if (stat_i.out_free) begin
            r_q     <= r_q + 7'd1;
            state_q <= o_last ? ST_IDLE : ST_OBIAS;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.src       = SRC_NONE;
    cmd_o.row       = r_q[5:0];
    cmd_o.col       = c_q[5:0];
    cmd_o.tbl_wr    = accept && action_i == ACT_WRITE;
    cmd_o.elem_wr   = accept && action_i == ACT_ELEM;
    cmd_o.clr       = accept && action_i == ACT_CLEAR;
    cmd_o.out_last  = o_last;
    case (state_q)
      ST_NBIAS: begin
        cmd_o.src     = SRC_BIASN;
        cmd_o.acc_clr = 1'b1;
      end
      ST_NIN: begin
        cmd_o.src       = SRC_IN;
        cmd_o.div_start = c_q == 7'd0;
      end
      ST_NREC:  cmd_o.src = SRC_REC;
      ST_NNET: begin
        cmd_o.src    = SRC_XR;
        cmd_o.net_ld = 1'b1;
      end
      ST_NTANH: cmd_o.tanh_ld = 1'b1;
      ST_NDIV:  cmd_o.upd_mul = !stat_i.div_busy;
      ST_NUPD:  cmd_o.upd_wr  = 1'b1;
      ST_COPY:  cmd_o.src     = SRC_COPY;
      ST_OBIAS: begin
        cmd_o.src     = SRC_BIASO;
        cmd_o.acc_clr = 1'b1;
      end
      ST_OMAC:  cmd_o.src    = SRC_OUT;
      ST_OWAIT: cmd_o.out_ld = stat_i.out_free;
      default: begin
      end
    endcase
  end

endmodule
